// ===== rtl/core/hbc_pkg.sv =====
package hbc_pkg;

  localparam int BLOCK_LEN_DEF = 512;
  localparam int NUM_DIR_DEF   = 37;

  localparam int SAMPLE_W  = 16;
  localparam int PAIR_W    = 2 * SAMPLE_W;
  localparam int CMD_W     = 1;
  localparam int DIR_W     = 7;
  localparam int TDIR_W    = 6;
  localparam int TAP_IDX_W = 9;

  // Q2.30 products back to Q1.15, round half up
  localparam int FRAC_W   = 15;
  localparam int RND_BIAS = 1 << (FRAC_W - 1);

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_AUDIO = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_CONV
  } hbc_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } hbc_eng_stat_t;

endpackage

// ===== rtl/core/hbc_if.sv =====
interface hbc_in_if;
  import hbc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic [TDIR_W-1:0]          table_direction;
  logic [TAP_IDX_W-1:0]       tap_index;
  logic signed [SAMPLE_W-1:0] tap_left;
  logic signed [SAMPLE_W-1:0] tap_right;
  logic signed [SAMPLE_W-1:0] audio_sample;

  modport source (
    output valid, cmd, table_direction, tap_index, tap_left, tap_right, audio_sample,
    input  ready
  );
  modport sink (
    input  valid, cmd, table_direction, tap_index, tap_left, tap_right, audio_sample,
    output ready
  );
endinterface

interface hbc_out_if;
  import hbc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic                       block_end;

  modport source (
    output valid, out_left, out_right, block_end,
    input  ready
  );
  modport sink (
    input  valid, out_left, out_right, block_end,
    output ready
  );
endinterface

// ===== rtl/core/hbc_resp_store.sv =====
module hbc_resp_store #(
  parameter int BLOCK_LEN      = hbc_pkg::BLOCK_LEN_DEF,
  parameter int NUM_DIRECTIONS = hbc_pkg::NUM_DIR_DEF,
  localparam int Depth         = NUM_DIRECTIONS * BLOCK_LEN,
  localparam int AddrW         = $clog2(Depth)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [AddrW-1:0]            wr_addr_i,
  input  logic [hbc_pkg::PAIR_W-1:0]  wr_data_i,
  input  logic [AddrW-1:0]            rd_addr_i,
  output logic [hbc_pkg::PAIR_W-1:0]  rd_data_o,
  output logic                        ready_o
);
  import hbc_pkg::*;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  logic [PAIR_W-1:0] mem [Depth];
  logic [PAIR_W-1:0] rd_data_q;
  logic              clear_q, clear_d;
  logic [AddrW-1:0]  clr_cnt_q, clr_cnt_d;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [PAIR_W-1:0] wdata;

  // sweep zeros through every entry after reset
  always_comb begin
    clear_d   = clear_q;
    clr_cnt_d = clr_cnt_q;
    if (clear_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == LastAddr) begin
        clear_d = 1'b0;
      end
    end
  end

  always_comb begin
    we    = clear_q | wr_en_i;
    waddr = clear_q ? clr_cnt_q : wr_addr_i;
    wdata = clear_q ? '0 : wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q   <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clear_q   <= clear_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = ~clear_q;

endmodule

// ===== rtl/core/hbc_block_store.sv =====
module hbc_block_store #(
  parameter int BLOCK_LEN = hbc_pkg::BLOCK_LEN_DEF,
  localparam int IdxW     = $clog2(BLOCK_LEN)
) (
  input  logic                          clk_i,
  input  logic [IdxW-1:0]               wr_addr_i,
  input  logic                          in_we_i,
  input  logic [hbc_pkg::SAMPLE_W-1:0]  in_data_i,
  input  logic                          out_we_i,
  input  logic [hbc_pkg::PAIR_W-1:0]    out_data_i,
  input  logic [IdxW-1:0]               rd_addr_i,
  output logic [hbc_pkg::SAMPLE_W-1:0]  rd_in_o,
  output logic [hbc_pkg::PAIR_W-1:0]    rd_out_o
);
  import hbc_pkg::*;

  localparam int WordW = SAMPLE_W + PAIR_W;

  // low field: input sample, high field: stereo result pair
  logic [WordW-1:0] mem [BLOCK_LEN];
  logic [WordW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (in_we_i) begin
      mem[wr_addr_i][SAMPLE_W-1:0] <= in_data_i;
    end
    if (out_we_i) begin
      mem[wr_addr_i][WordW-1:SAMPLE_W] <= out_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_in_o  = rd_data_q[SAMPLE_W-1:0];
  assign rd_out_o = rd_data_q[WordW-1:SAMPLE_W];

endmodule

// ===== rtl/core/hbc_mac_engine.sv =====
module hbc_mac_engine #(
  parameter int BLOCK_LEN      = hbc_pkg::BLOCK_LEN_DEF,
  parameter int NUM_DIRECTIONS = hbc_pkg::NUM_DIR_DEF,
  localparam int IdxW          = $clog2(BLOCK_LEN),
  localparam int RespAddrW     = $clog2(NUM_DIRECTIONS * BLOCK_LEN),
  localparam int EntryW        = $clog2(NUM_DIRECTIONS)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [EntryW-1:0]                    entry_i,
  input  logic                                 swap_i,
  output logic [RespAddrW-1:0]                 resp_raddr_o,
  input  logic [hbc_pkg::PAIR_W-1:0]           resp_rdata_i,
  output logic [IdxW-1:0]                      blk_raddr_o,
  input  logic signed [hbc_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                 blk_we_o,
  output logic [IdxW-1:0]                      blk_waddr_o,
  output logic [hbc_pkg::PAIR_W-1:0]           blk_wdata_o,
  output hbc_pkg::hbc_eng_stat_t               stat_o
);
  import hbc_pkg::*;

  localparam int ProdW = 2 * SAMPLE_W;
  localparam int AccW  = ProdW + IdxW;
  localparam int AccW1 = AccW + 1;
  localparam logic [IdxW-1:0] Last = IdxW'(BLOCK_LEN - 1);

  function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [AccW-1:0] a);
    logic signed [AccW1-1:0] t;
    logic signed [AccW1-1:0] q;
    t = AccW1'(a) + AccW1'(RND_BIAS);
    q = t >>> FRAC_W;
    if (q > AccW1'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (q < AccW1'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return q[SAMPLE_W-1:0];
  endfunction

  // issue counters
  logic                 issue_q;
  logic [IdxW-1:0]      n_q, k_q, tap_q;
  logic [RespAddrW-1:0] base_q;
  logic                 swap_q;

  // stage 1: memory data valid
  logic            s1_vld_q, s1_first_q, s1_last_q;
  logic [IdxW-1:0] s1_row_q;
  // stage 2: products
  logic                    s2_vld_q, s2_first_q, s2_last_q;
  logic [IdxW-1:0]         s2_row_q;
  logic signed [ProdW-1:0] p_l_q, p_r_q;
  // stage 3: sums
  logic signed [AccW-1:0]  acc_l_q, acc_r_q;
  logic                    s3_done_q;
  logic [IdxW-1:0]         s3_row_q;

  logic signed [SAMPLE_W-1:0] tap_l, tap_r;
  logic [SAMPLE_W-1:0]        res_l, res_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      n_q     <= '0;
      k_q     <= '0;
      tap_q   <= '0;
    end else if (start_i) begin
      issue_q <= 1'b1;
      n_q     <= '0;
      k_q     <= '0;
      tap_q   <= '0;
    end else if (issue_q) begin
      if (k_q == Last) begin
        k_q <= '0;
        if (n_q == Last) begin
          issue_q <= 1'b0;
        end else begin
          n_q   <= n_q + 1'b1;
          tap_q <= n_q + 1'b1;
        end
      end else begin
        k_q   <= k_q + 1'b1;
        // walk the response backwards, wrap around the block
        tap_q <= (tap_q == '0) ? Last : tap_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      base_q <= RespAddrW'(RespAddrW'(entry_i) * RespAddrW'(BLOCK_LEN));
      swap_q <= swap_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_done_q <= 1'b0;
    end else begin
      s1_vld_q  <= issue_q;
      s2_vld_q  <= s1_vld_q;
      s3_done_q <= s2_vld_q & s2_last_q;
    end
  end

  assign tap_l = $signed(resp_rdata_i[SAMPLE_W-1:0]);
  assign tap_r = $signed(resp_rdata_i[PAIR_W-1:SAMPLE_W]);

  always_ff @(posedge clk_i) begin
    s1_first_q <= (k_q == '0);
    s1_last_q  <= (k_q == Last);
    s1_row_q   <= n_q;

    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_row_q   <= s1_row_q;
    p_l_q      <= sample_i * tap_l;
    p_r_q      <= sample_i * tap_r;

    if (s2_vld_q) begin
      acc_l_q <= s2_first_q ? AccW'(p_l_q) : acc_l_q + AccW'(p_l_q);
      acc_r_q <= s2_first_q ? AccW'(p_r_q) : acc_r_q + AccW'(p_r_q);
    end
    s3_row_q <= s2_row_q;
  end

  assign res_l = round_sat(acc_l_q);
  assign res_r = round_sat(acc_r_q);

  assign resp_raddr_o = base_q + RespAddrW'(tap_q);
  assign blk_raddr_o  = k_q;
  assign blk_we_o     = s3_done_q;
  assign blk_waddr_o  = s3_row_q;
  assign blk_wdata_o  = swap_q ? {res_l, res_r} : {res_r, res_l};

  assign stat_o.busy = issue_q | s1_vld_q | s2_vld_q | s3_done_q;
  assign stat_o.done = s3_done_q & (s3_row_q == Last);

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !stat_o.busy)
    else $error("engine started while busy");

  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.done |-> !issue_q && !s1_vld_q && !s2_vld_q)
    else $error("block finished with products still in flight");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && s1_first_q && s2_vld_q |-> s2_last_q)
    else $error("new row entered before previous row closed");

endmodule

// ===== rtl/core/hrtf_block_convolver.sv =====
// Load transfer: written to the response memory at the transfer edge; input stays ready.
// Audio transfer: result register loads in the fetch state once free (output stall holds it).
// Last sample of a block: the MAC engine then runs over every tap of every output sample,
// one left/right tap pair per cycle from the response memory port, and no item is taken
// until it finishes. No item is taken while a fetch is pending either.
// Reset: response memory is swept to zero over NUM_DIRECTIONS*BLOCK_LEN entries (18944).
module hrtf_block_convolver #(
  parameter int BLOCK_LEN      = hbc_pkg::BLOCK_LEN_DEF,
  parameter int NUM_DIRECTIONS = hbc_pkg::NUM_DIR_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hbc_pkg::DIR_W-1:0]  cfg_wdata_i,
  hbc_in_if.sink                     in_i,
  hbc_out_if.source                  out_o
);
  import hbc_pkg::*;

  localparam int IdxW      = $clog2(BLOCK_LEN);
  localparam int RespAddrW = $clog2(NUM_DIRECTIONS * BLOCK_LEN);
  localparam int EntryW    = $clog2(NUM_DIRECTIONS);
  localparam int FullCircle = 2 * (NUM_DIRECTIONS - 1);
  localparam logic [IdxW-1:0] LastPos = IdxW'(BLOCK_LEN - 1);

  hbc_state_e state_q, state_d;

  logic [DIR_W-1:0] dir_q;
  logic [IdxW-1:0]  pos_q, fetch_pos_q;
  logic             fetch_last_q;
  logic             primed_q;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_left_q, out_right_q;
  logic                       out_end_q;

  logic in_xfer, in_audio, in_ready;
  logic out_free, out_load;

  logic                 resp_we, resp_ready;
  logic [RespAddrW-1:0] resp_waddr, resp_raddr;
  logic [PAIR_W-1:0]    resp_rdata;

  logic [IdxW-1:0]     blk_raddr, blk_waddr;
  logic [SAMPLE_W-1:0] blk_rd_in;
  logic [PAIR_W-1:0]   blk_rd_out;

  logic                eng_start;
  logic [IdxW-1:0]     eng_blk_raddr, eng_blk_waddr;
  logic                eng_blk_we;
  logic [PAIR_W-1:0]   eng_blk_wdata;
  hbc_eng_stat_t       eng_stat;

  logic [DIR_W-1:0]  dir_sat, dir_entry;
  logic              dir_swap;
  logic [EntryW-1:0] entry;

  assign in_xfer  = in_i.valid & in_ready;
  assign in_audio = in_xfer & (in_i.cmd == CMD_AUDIO);
  assign out_free = ~out_valid_q | out_o.ready;

  // past 180 degrees, mirror into the table and swap ears
  always_comb begin
    dir_sat   = (dir_q >= DIR_W'(FullCircle)) ? DIR_W'(FullCircle - 1) : dir_q;
    dir_swap  = dir_sat > DIR_W'(NUM_DIRECTIONS - 1);
    dir_entry = dir_swap ? DIR_W'(FullCircle) - dir_sat : dir_sat;
    entry     = EntryW'(dir_entry);
  end

  // drop loads outside the table
  always_comb begin
    resp_we = in_xfer && (in_i.cmd == CMD_LOAD)
              && (int'(in_i.table_direction) < NUM_DIRECTIONS)
              && (int'(in_i.tap_index) < BLOCK_LEN);
    resp_waddr = RespAddrW'(RespAddrW'(in_i.table_direction) * RespAddrW'(BLOCK_LEN)
                            + RespAddrW'(in_i.tap_index));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (resp_ready) state_d = ST_IDLE;
      ST_IDLE:  if (in_audio) state_d = ST_FETCH;
      ST_FETCH: if (out_free) state_d = fetch_last_q ? ST_CONV : ST_IDLE;
      ST_CONV:  if (eng_stat.done) state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    eng_start = 1'b0;
    blk_raddr = pos_q;
    blk_waddr = pos_q;
    unique case (state_q)
      ST_CLEAR: begin
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_FETCH: begin
        // hold the read address until the result register frees up
        blk_raddr = fetch_pos_q;
        out_load  = out_free;
        eng_start = out_free & fetch_last_q;
      end
      ST_CONV: begin
        blk_raddr = eng_blk_raddr;
        blk_waddr = eng_blk_waddr;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      dir_q        <= '0;
      pos_q        <= '0;
      fetch_last_q <= 1'b0;
      primed_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        dir_q <= cfg_wdata_i;
      end
      if (in_audio) begin
        pos_q        <= (pos_q == LastPos) ? '0 : pos_q + 1'b1;
        fetch_last_q <= (pos_q == LastPos);
      end
      if (eng_stat.done) begin
        primed_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_audio) begin
      fetch_pos_q <= pos_q;
    end
    if (out_load) begin
      // the first block after reset plays silence
      out_left_q  <= primed_q ? $signed(blk_rd_out[SAMPLE_W-1:0]) : '0;
      out_right_q <= primed_q ? $signed(blk_rd_out[PAIR_W-1:SAMPLE_W]) : '0;
      out_end_q   <= fetch_last_q;
    end
  end

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.out_left  = out_left_q;
  assign out_o.out_right = out_right_q;
  assign out_o.block_end = out_end_q;

  hbc_resp_store #(
    .BLOCK_LEN      (BLOCK_LEN),
    .NUM_DIRECTIONS (NUM_DIRECTIONS)
  ) u_resp_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (resp_we),
    .wr_addr_i (resp_waddr),
    .wr_data_i ({in_i.tap_right, in_i.tap_left}),
    .rd_addr_i (resp_raddr),
    .rd_data_o (resp_rdata),
    .ready_o   (resp_ready)
  );

  hbc_block_store #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_block_store (
    .clk_i      (clk_i),
    .wr_addr_i  (blk_waddr),
    .in_we_i    (in_audio),
    .in_data_i  (in_i.audio_sample),
    .out_we_i   (eng_blk_we),
    .out_data_i (eng_blk_wdata),
    .rd_addr_i  (blk_raddr),
    .rd_in_o    (blk_rd_in),
    .rd_out_o   (blk_rd_out)
  );

  hbc_mac_engine #(
    .BLOCK_LEN      (BLOCK_LEN),
    .NUM_DIRECTIONS (NUM_DIRECTIONS)
  ) u_mac_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (eng_start),
    .entry_i      (entry),
    .swap_i       (dir_swap),
    .resp_raddr_o (resp_raddr),
    .resp_rdata_i (resp_rdata),
    .blk_raddr_o  (eng_blk_raddr),
    .sample_i     ($signed(blk_rd_in)),
    .blk_we_o     (eng_blk_we),
    .blk_waddr_o  (eng_blk_waddr),
    .blk_wdata_o  (eng_blk_wdata),
    .stat_o       (eng_stat)
  );

  a_start_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_start |-> pos_q == '0)
    else $error("convolution started before the block wrapped");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !eng_stat.busy)
    else $error("engine active while taking items");

  a_block_to_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && fetch_last_q |=> state_q == ST_CONV && eng_stat.busy)
    else $error("last sample of a block did not start the convolution");

endmodule
